FILE: src/fixed_frame_checksum_parser_assert.svh
// Assertion macros for the checker file of the frame parser.
`ifndef FIXED_FRAME_CHECKSUM_PARSER_ASSERT_SVH
`define FIXED_FRAME_CHECKSUM_PARSER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FFCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FFCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ffcp_pkg.sv
// Shared constants and types of the fixed frame checksum parser.
`timescale 1ns / 1ps

package ffcp_pkg;

    localparam logic [7:0] FFCP_HDR_BYTE     = 8'hAA;
    localparam logic [7:0] FFCP_TYPE_ANGLE   = 8'hF1;
    localparam logic [7:0] FFCP_TYPE_CURRENT = 8'hF2;
    localparam logic [7:0] FFCP_TYPE_STATUS  = 8'hF3;

    // Bytes 0..27 form the body, byte 28 carries the sum.
    localparam int         FFCP_BODY_LEN  = 28;
    localparam logic [4:0] FFCP_LAST_POS  = 5'd28;

    // Bytes 3..26 are all that any result needs.
    localparam int FFCP_PAYLOAD_FIRST = 3;
    localparam int FFCP_PAYLOAD_BYTES = 24;
    localparam int FFCP_PAYLOAD_W     = 8 * FFCP_PAYLOAD_BYTES;

    localparam int FFCP_QUEUE_DEPTH = 2;

    localparam logic [2:0] FFCP_ST_ANGLE    = 3'd0;
    localparam logic [2:0] FFCP_ST_CURRENT  = 3'd1;
    localparam logic [2:0] FFCP_ST_STATUS   = 3'd2;
    localparam logic [2:0] FFCP_ST_HDR_ERR  = 3'd3;
    localparam logic [2:0] FFCP_ST_SUM_ERR  = 3'd4;
    localparam logic [2:0] FFCP_ST_UNKNOWN  = 3'd5;

    // One judged frame: verdict plus bytes 3..26, byte 3 most significant.
    typedef struct packed {
        logic [2:0]                status;
        logic [FFCP_PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: src/ffcp_front.sv
// Front end: counts bytes, keeps the frame body and sum, judges each frame.
`timescale 1ns / 1ps

module ffcp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_rx_byte,
    input  ffcp_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output ffcp_pkg::t_entry    o_entry
);
    import ffcp_pkg::*;

    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [7:0] r_body [0:FFCP_BODY_LEN-1];

    logic       last_beat;
    logic       accept;
    logic       hdr_ok;
    logic [2:0] status;

    assign last_beat = (r_pos >= FFCP_LAST_POS);
    // Hold the checksum beat only when there is no room for its verdict.
    assign o_stall   = last_beat && i_q_stat.full;
    assign accept    = i_valid && !o_stall;
    assign o_push    = accept && last_beat;

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (accept) begin
            if (last_beat) begin
                n_pos = '0;
                n_sum = '0;
            end else begin
                n_pos = r_pos + 5'd1;
                n_sum = r_sum + i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // Shift the body in; after 28 beats byte 0 sits at the head.
    always_ff @(posedge i_clk) begin
        if (accept && !last_beat) begin
            for (int i = 0; i < FFCP_BODY_LEN - 1; i++) begin
                r_body[i] <= r_body[i+1];
            end
            r_body[FFCP_BODY_LEN-1] <= i_rx_byte;
        end
    end

    assign hdr_ok = (r_body[0] == FFCP_HDR_BYTE) && (r_body[1] == FFCP_HDR_BYTE);

    always_comb begin
        if (!hdr_ok) begin
            status = FFCP_ST_HDR_ERR;
        end else if (r_sum != i_rx_byte) begin
            status = FFCP_ST_SUM_ERR;
        end else if (r_body[2] == FFCP_TYPE_ANGLE) begin
            status = FFCP_ST_ANGLE;
        end else if (r_body[2] == FFCP_TYPE_CURRENT) begin
            status = FFCP_ST_CURRENT;
        end else if (r_body[2] == FFCP_TYPE_STATUS) begin
            status = FFCP_ST_STATUS;
        end else begin
            status = FFCP_ST_UNKNOWN;
        end
    end

    always_comb begin
        o_entry.status = status;
        for (int i = 0; i < FFCP_PAYLOAD_BYTES; i++) begin
            o_entry.payload[FFCP_PAYLOAD_W-1-8*i -: 8] = r_body[FFCP_PAYLOAD_FIRST+i];
        end
    end

endmodule

FILE: src/ffcp_queue.sv
// Short queue of judged frames between the front and back ends.
`timescale 1ns / 1ps

module ffcp_queue #(
    parameter int DEPTH = ffcp_pkg::FFCP_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ffcp_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output ffcp_pkg::t_entry  o_head,
    output ffcp_pkg::t_q_stat o_stat
);
    import ffcp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: src/ffcp_back.sv
// Back end: unpacks a judged frame into result fields and holds the output beat.
`timescale 1ns / 1ps

module ffcp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffcp_pkg::t_entry  i_head,
    input  ffcp_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_frame_status,
    output logic [31:0]       o_word0,
    output logic [31:0]       o_word1,
    output logic [31:0]       o_word2,
    output logic [31:0]       o_word3,
    output logic [31:0]       o_word4,
    output logic [31:0]       o_word5,
    output logic [63:0]       o_mode_bytes,
    output logic [47:0]       o_motor_enables
);
    import ffcp_pkg::*;

    // Offsets into the payload, which starts at byte 3.
    localparam int MODE_TOP  = FFCP_PAYLOAD_W - 1 - 8 * (4 - FFCP_PAYLOAD_FIRST);
    localparam int MOTOR_TOP = FFCP_PAYLOAD_W - 1 - 8 * (20 - FFCP_PAYLOAD_FIRST);

    logic        r_valid;
    logic        load;
    logic        is_words;
    logic        is_status;
    logic [31:0] words [0:5];

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !i_q_stat.empty;

    assign is_words  = (i_head.status == FFCP_ST_ANGLE) || (i_head.status == FFCP_ST_CURRENT);
    assign is_status = (i_head.status == FFCP_ST_STATUS);

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            words[k] = is_words ? i_head.payload[FFCP_PAYLOAD_W-1-32*k -: 32] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_frame_status  <= i_head.status;
            o_word0         <= words[0];
            o_word1         <= words[1];
            o_word2         <= words[2];
            o_word3         <= words[3];
            o_word4         <= words[4];
            o_word5         <= words[5];
            o_mode_bytes    <= is_status ? i_head.payload[MODE_TOP -: 64] : 64'd0;
            o_motor_enables <= is_status ? i_head.payload[MOTOR_TOP -: 48] : 48'd0;
        end
    end

    assign o_valid = r_valid;

endmodule

FILE: src/fixed_frame_checksum_parser.sv
// Top level of the fixed frame checksum parser.
`timescale 1ns / 1ps

// Takes one received byte per cycle and cuts the stream into 29-byte frames
// counted from reset, never searching for a frame boundary. Bytes 0..27 are
// shifted into a body register and summed; on byte 28 the front end judges
// the frame (header, then checksum, then type) and pushes the verdict with
// bytes 3..26 into a short queue. The back end unpacks the queue head into
// the output register, taking it from the queue once the output is free.
// Input rate is one byte per cycle; o_stall rises only on a checksum byte
// while the queue is full, which a sink that takes one result per frame
// never causes.
module fixed_frame_checksum_parser #(
    parameter int QUEUE_DEPTH = ffcp_pkg::FFCP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_frame_status,
    output logic [31:0] o_word0,
    output logic [31:0] o_word1,
    output logic [31:0] o_word2,
    output logic [31:0] o_word3,
    output logic [31:0] o_word4,
    output logic [31:0] o_word5,
    output logic [63:0] o_mode_bytes,
    output logic [47:0] o_motor_enables
);
    import ffcp_pkg::*;

    logic    push;
    logic    pop;
    t_entry  push_entry;
    t_entry  head;
    t_q_stat q_stat;

    ffcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    ffcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    ffcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_frame_status  (o_frame_status),
        .o_word0         (o_word0),
        .o_word1         (o_word1),
        .o_word2         (o_word2),
        .o_word3         (o_word3),
        .o_word4         (o_word4),
        .o_word5         (o_word5),
        .o_mode_bytes    (o_mode_bytes),
        .o_motor_enables (o_motor_enables)
    );

endmodule

FILE: src/ffcp_checker.sv
// Port-level checks of the frame parser, bound to its top level.
`timescale 1ns / 1ps
`include "fixed_frame_checksum_parser_assert.svh"

module ffcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_rx_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_frame_status,
    input logic [31:0] o_word0,
    input logic [31:0] o_word1,
    input logic [31:0] o_word2,
    input logic [31:0] o_word3,
    input logic [31:0] o_word4,
    input logic [31:0] o_word5,
    input logic [63:0] o_mode_bytes,
    input logic [47:0] o_motor_enables
);
    import ffcp_pkg::*;

    logic         words_zero;
    logic         status_zero;
    logic         in_held;
    logic         out_held;
    logic         is_chan;
    logic [306:0] out_fields;

    assign words_zero = (o_word0 == '0) && (o_word1 == '0) && (o_word2 == '0)
                     && (o_word3 == '0) && (o_word4 == '0) && (o_word5 == '0);
    assign status_zero = (o_mode_bytes == '0) && (o_motor_enables == '0);
    assign in_held     = i_valid && o_stall;
    assign out_held    = o_valid && i_stall;
    assign is_chan     = (o_frame_status == FFCP_ST_ANGLE)
                      || (o_frame_status == FFCP_ST_CURRENT);
    assign out_fields  = {o_frame_status, o_word0, o_word1, o_word2, o_word3, o_word4,
                          o_word5, o_mode_bytes, o_motor_enables};

    `FFCP_ASSERT(a_in_hold, i_clk, i_rst_n, in_held |=> i_valid && $stable(i_rx_byte), "stalled input beat changed")
    `FFCP_ASSERT(a_out_hold, i_clk, i_rst_n, out_held |=> o_valid && $stable(out_fields), "stalled result beat changed")
    `FFCP_ASSERT(a_status_range, i_clk, i_rst_n, o_valid |-> o_frame_status <= FFCP_ST_UNKNOWN, "frame status out of range")
    `FFCP_ASSERT(a_words_zero, i_clk, i_rst_n, o_valid && !is_chan |-> words_zero, "channel words set on a non-channel frame")
    `FFCP_ASSERT_ALWAYS(a_status_fields_zero, i_clk, !i_rst_n || !o_valid || o_frame_status == FFCP_ST_STATUS || status_zero, "status bytes set on a non-status frame")

endmodule

bind fixed_frame_checksum_parser ffcp_checker u_ffcp_checker (.*);

FILE: sim/tb.sv
// Self-checking testbench for the fixed frame checksum parser.
`timescale 1ns / 1ps

module tb;
    import ffcp_pkg::*;

    localparam int FRAME_BYTES = 29;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int TOTAL_BYTES = 900;

    typedef struct packed {
        logic [2:0]       status;
        logic [5:0][31:0] words;
        logic [63:0]      mode;
        logic [47:0]      enables;
    } t_frame_result;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;
    typedef enum int {FAULT_NONE, FAULT_HDR0, FAULT_HDR1, FAULT_BOTH, FAULT_SUM} t_fault;

    class frame_scoreboard;
        logic [4:0]    pos;
        logic [7:0]    sum;
        logic [7:0]    body [FFCP_BODY_LEN];
        t_frame_result expected_q [$];
        int            errors;
        int            frames_judged;
        int            status_count [6];

        function new();
            pos = '0;
            sum = '0;
            errors = 0;
            frames_judged = 0;
            foreach (body[i]) body[i] = '0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        // Track one accepted input beat; on the checksum byte queue the verdict.
        function void note_byte(logic [7:0] b);
            t_frame_result r;
            if (pos < FFCP_LAST_POS) begin
                body[pos] = b;
                sum = sum + b;
                pos = pos + 5'd1;
                return;
            end
            r = '0;
            if (body[0] != FFCP_HDR_BYTE || body[1] != FFCP_HDR_BYTE) begin
                r.status = FFCP_ST_HDR_ERR;
            end else if (sum != b) begin
                r.status = FFCP_ST_SUM_ERR;
            end else if (body[2] == FFCP_TYPE_ANGLE || body[2] == FFCP_TYPE_CURRENT) begin
                r.status = (body[2] == FFCP_TYPE_ANGLE) ? FFCP_ST_ANGLE : FFCP_ST_CURRENT;
                for (int k = 0; k < 6; k++)
                    r.words[k] = {body[3+4*k], body[4+4*k], body[5+4*k], body[6+4*k]};
            end else if (body[2] == FFCP_TYPE_STATUS) begin
                r.status = FFCP_ST_STATUS;
                for (int i = 0; i < 8; i++) r.mode = {r.mode[55:0], body[4+i]};
                for (int i = 0; i < 6; i++) r.enables = {r.enables[39:0], body[20+i]};
            end else begin
                r.status = FFCP_ST_UNKNOWN;
            end
            pos = '0;
            sum = '0;
            frames_judged++;
            status_count[r.status]++;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            for (int k = 0; k < 6; k++) begin
                if (got.words[k] !== want.words[k]) begin
                    $display("%0t: word%0d expected %h got %h", $time, k,
                             want.words[k], got.words[k]);
                    errors++;
                end
            end
            if (got.mode !== want.mode) begin
                $display("%0t: mode_bytes expected %h got %h", $time, want.mode, got.mode);
                errors++;
            end
            if (got.enables !== want.enables) begin
                $display("%0t: motor_enables expected %h got %h", $time,
                         want.enables, got.enables);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_frame_status;
    logic [31:0] o_word0, o_word1, o_word2, o_word3, o_word4, o_word5;
    logic [63:0] o_mode_bytes;
    logic [47:0] o_motor_enables;

    fixed_frame_checksum_parser i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_word0        (o_word0),
        .o_word1        (o_word1),
        .o_word2        (o_word2),
        .o_word3        (o_word3),
        .o_word4        (o_word4),
        .o_word5        (o_word5),
        .o_mode_bytes   (o_mode_bytes),
        .o_motor_enables(o_motor_enables)
    );

    frame_scoreboard sb = new();

    logic in_beat  = 1'b0;
    logic out_beat = 1'b0;
    int   bytes_sent = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Sample both handshakes on the falling edge ahead of the rising edge that takes them.
    always @(negedge i_clk) begin
        in_beat  = i_rst_n && i_valid && !o_stall;
        out_beat = i_rst_n && o_valid && !i_stall;
        if (out_beat)
            sb.check_result({o_frame_status,
                             {o_word5, o_word4, o_word3, o_word2, o_word1, o_word0},
                             o_mode_bytes, o_motor_enables});
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_beat || out_beat) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // Sink stall pattern: free runs, random chatter and holds.
    initial begin : sink_pattern
        int mode;
        int len;
        forever begin
            mode = $urandom_range(0, 2);
            len = (mode == 2) ? $urandom_range(1, 60) : $urandom_range(10, 120);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 2) == 0);
                    default: i_stall <= 1'b1;
                endcase
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!in_beat);
        sb.note_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    function automatic logic [7:0] random_non_header();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == FFCP_HDR_BYTE) b = ~b;
        return b;
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 2))
            0: return FFCP_TYPE_ANGLE;
            1: return FFCP_TYPE_CURRENT;
            default: return FFCP_TYPE_STATUS;
        endcase
    endfunction

    function automatic t_fill pick_fill();
        case ($urandom_range(0, 15))
            0: return FILL_ZERO;
            1: return FILL_ONES;
            default: return FILL_RANDOM;
        endcase
    endfunction

    task automatic send_frame(input logic [7:0] kind, input t_fill fill, input t_fault fault);
        logic [7:0] f [FRAME_BYTES];
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            case (fill)
                FILL_ZERO: f[i] = 8'h00;
                FILL_ONES: f[i] = 8'hFF;
                default:   f[i] = 8'($urandom_range(0, 255));
            endcase
        end
        f[0] = FFCP_HDR_BYTE;
        f[1] = FFCP_HDR_BYTE;
        f[2] = kind;
        if (fault == FAULT_HDR0 || fault == FAULT_BOTH) f[0] = random_non_header();
        if (fault == FAULT_HDR1 || fault == FAULT_BOTH) f[1] = random_non_header();
        for (int i = 0; i < FFCP_BODY_LEN; i++) s = s + f[i];
        // A lone header fault keeps a good sum, and FAULT_BOTH also breaks the sum, so the header verdict must win.
        f[28] = s;
        if (fault == FAULT_SUM || fault == FAULT_BOTH) f[28] = s + 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_BYTES; i++) push_byte(f[i]);
    endtask

    initial begin : stimulus
        int    pick;
        int    pad;
        logic [7:0] t;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames: every verdict and the payload extremes.
        send_frame(FFCP_TYPE_ANGLE,   FILL_ZERO,   FAULT_NONE);
        send_frame(FFCP_TYPE_ANGLE,   FILL_ONES,   FAULT_NONE);
        send_frame(FFCP_TYPE_CURRENT, FILL_RANDOM, FAULT_NONE);
        send_frame(FFCP_TYPE_CURRENT, FILL_ONES,   FAULT_NONE);
        send_frame(FFCP_TYPE_STATUS,  FILL_RANDOM, FAULT_NONE);
        send_frame(FFCP_TYPE_STATUS,  FILL_ONES,   FAULT_NONE);
        send_frame(FFCP_TYPE_STATUS,  FILL_ZERO,   FAULT_NONE);
        send_frame(FFCP_TYPE_ANGLE,   FILL_RANDOM, FAULT_HDR0);
        send_frame(FFCP_TYPE_ANGLE,   FILL_RANDOM, FAULT_HDR1);
        send_frame(FFCP_TYPE_STATUS,  FILL_RANDOM, FAULT_BOTH);
        send_frame(FFCP_TYPE_CURRENT, FILL_RANDOM, FAULT_SUM);
        send_frame(8'h00,             FILL_ZERO,   FAULT_NONE);
        send_frame(8'hFF,             FILL_ONES,   FAULT_NONE);
        send_frame(8'hF4,             FILL_RANDOM, FAULT_NONE);
        send_frame(8'hF0,             FILL_RANDOM, FAULT_SUM);

        while (bytes_sent < TOTAL_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(pick_type(), pick_fill(), FAULT_NONE);
            end else if (pick < 77) begin
                t = 8'($urandom_range(0, 255));
                if (t == FFCP_TYPE_ANGLE || t == FFCP_TYPE_CURRENT || t == FFCP_TYPE_STATUS)
                    t = 8'h00;
                send_frame(t, pick_fill(), FAULT_NONE);
            end else if (pick < 83) begin
                send_frame(pick_type(), pick_fill(), FAULT_SUM);
            end else if (pick < 89) begin
                send_frame(pick_type(), pick_fill(), t_fault'(FAULT_HDR0 + $urandom_range(0, 2)));
            end else if (pick < 94) begin
                repeat (FRAME_BYTES) push_byte(8'($urandom_range(0, 255)));
            end else begin
                // Slip the framing, send a good frame off the boundary, then realign.
                repeat ($urandom_range(1, 28)) push_byte(8'($urandom_range(0, 255)));
                send_frame(pick_type(), FILL_RANDOM, FAULT_NONE);
                pad = (FRAME_BYTES - bytes_sent % FRAME_BYTES) % FRAME_BYTES;
                repeat (pad) push_byte(8'($urandom_range(0, 255)));
            end
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("tb: %0d bytes in, %0d frames judged", bytes_sent, sb.frames_judged);
        $display("tb: angle %0d, current %0d, status %0d, header %0d, sum %0d, unknown %0d",
                 sb.status_count[FFCP_ST_ANGLE], sb.status_count[FFCP_ST_CURRENT],
                 sb.status_count[FFCP_ST_STATUS], sb.status_count[FFCP_ST_HDR_ERR],
                 sb.status_count[FFCP_ST_SUM_ERR], sb.status_count[FFCP_ST_UNKNOWN]);
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
